>>> rtl/grid_trilinear_coord_map_macros.svh
// Assertion helpers for the grid trilinear coordinate map.
`ifndef GRID_TRILINEAR_COORD_MAP_MACROS_SVH
`define GRID_TRILINEAR_COORD_MAP_MACROS_SVH
`ifndef SYNTHESIS
`define GTCM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("gtcm assertion failed");
`define GTCM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("gtcm assertion failed");
`else
`define GTCM_ASSERT_IMP(lbl, ante, cons)
`define GTCM_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> rtl/gtcm_pkg.sv
package gtcm_pkg;

  localparam int unsigned GRID_X_DEF = 16;
  localparam int unsigned GRID_Y_DEF = 16;
  localparam int unsigned GRID_Z_DEF = 16;

  localparam int unsigned STORE_AW = 12;
  localparam int unsigned STORE_DEPTH = 1 << STORE_AW;
  localparam int unsigned FRAC_W = 13;
  localparam int unsigned FRAC_SHIFT = 12;
  localparam int unsigned COORD_W = 32;
  localparam int unsigned NUM_CORNERS = 8;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_MAP_WIN = 2'd1,
    OP_MAP_RAW = 2'd2,
    OP_NONE    = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    REG_WIN_XA  = 3'd0,
    REG_WIN_XB  = 3'd1,
    REG_WIN_YA  = 3'd2,
    REG_WIN_YB  = 3'd3,
    REG_WIN_ZA  = 3'd4,
    REG_WIN_ZB  = 3'd5,
    REG_ORIGIN  = 3'd6,
    REG_UNUSED  = 3'd7
  } reg_e;

  typedef struct packed {
    op_e  op;
    logic ok;
  } meta_t;

endpackage

>>> rtl/gtcm_lerp.sv
module gtcm_lerp
  import gtcm_pkg::*;
#(
  parameter int unsigned IN_W  = 32,
  parameter int unsigned OUT_W = 34
) (
  input  logic                    clk_i,
  input  logic                    en_i,
  input  logic signed [IN_W-1:0]  lo_i,
  input  logic signed [IN_W-1:0]  hi_i,
  input  logic signed [FRAC_W-1:0] frac_i,
  output logic signed [OUT_W-1:0] q_o
);

  localparam int unsigned SW = IN_W + FRAC_W + 3;

  logic signed [FRAC_W+1:0] w_lo;
  logic signed [FRAC_W+1:0] w_hi;
  logic signed [SW-1:0]     prod_lo;
  logic signed [SW-1:0]     prod_hi;
  logic signed [SW-1:0]     sum;
  logic signed [SW-1:0]     shifted;
  logic signed [OUT_W-1:0]  q_q;

  assign w_hi    = (FRAC_W + 2)'(frac_i);
  assign w_lo    = (FRAC_W + 2)'(1 << FRAC_SHIFT) - w_hi;
  assign prod_lo = SW'(lo_i) * SW'(w_lo);
  assign prod_hi = SW'(hi_i) * SW'(w_hi);
  assign sum     = prod_lo + prod_hi + SW'(1 << (FRAC_SHIFT - 1));
  assign shifted = sum >>> FRAC_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      q_q <= OUT_W'(shifted);
    end
  end

  assign q_o = q_q;

endmodule

>>> rtl/grid_trilinear_coord_map.sv
// Trilinear grid coordinate map. Load beats write one grid point into the point store and map
// beats interpolate the eight surrounding points. The block takes one beat per cycle while the
// output is not stalled; the whole pipeline holds while a result waits for m_axis_tready. Each
// beat passes address split, store read, and three interpolation stages ahead of the output
// register. The store is kept as eight copies, one read port per corner, all written by each
// load. Store contents are undefined until written, so no clearing pass runs after reset.
`include "grid_trilinear_coord_map_macros.svh"

module grid_trilinear_coord_map
  import gtcm_pkg::*;
#(
  parameter int unsigned GRID_X = GRID_X_DEF,
  parameter int unsigned GRID_Y = GRID_Y_DEF,
  parameter int unsigned GRID_Z = GRID_Z_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // grid_pos_x[16:0], grid_pos_y[33:17], grid_pos_z[50:34], load_address[62:51],
  // load_point_x[94:63], load_point_y[126:95], load_point_z[158:127], zero pad[159]
  input  logic [159:0] s_axis_tdata_i,
  // operation[1:0]
  input  logic [1:0]   s_axis_tuser_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // mapped_x[31:0], mapped_y[63:32], mapped_z[95:64]
  output logic [95:0]  m_axis_tdata_o,
  // clipped[0], out_of_grid[1]
  output logic [1:0]   m_axis_tuser_o,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [4:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned SIZE [3] = '{GRID_X, GRID_Y, GRID_Z};
  localparam int unsigned L1_W = COORD_W + 2;
  localparam int unsigned L2_W = COORD_W + 4;
  localparam int unsigned L3_W = COORD_W + 6;

  // Configuration registers.
  logic signed [31:0] win_a_q [3];
  logic signed [31:0] win_b_q [3];
  logic [11:0]        origin_q;
  logic               cfg_wr;
  reg_e               cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int a = 0; a < 3; a++) begin
        win_a_q[a] <= 32'sh8000_0000;
        win_b_q[a] <= 32'sh7FFF_FFFF;
      end
      origin_q <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WIN_XA: win_a_q[0] <= pwdata;
        REG_WIN_XB: win_b_q[0] <= pwdata;
        REG_WIN_YA: win_a_q[1] <= pwdata;
        REG_WIN_YB: win_b_q[1] <= pwdata;
        REG_WIN_ZA: win_a_q[2] <= pwdata;
        REG_WIN_ZB: win_b_q[2] <= pwdata;
        REG_ORIGIN: origin_q   <= pwdata[11:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WIN_XA: prdata = win_a_q[0];
      REG_WIN_XB: prdata = win_b_q[0];
      REG_WIN_YA: prdata = win_a_q[1];
      REG_WIN_YB: prdata = win_b_q[1];
      REG_WIN_ZA: prdata = win_a_q[2];
      REG_WIN_ZB: prdata = win_b_q[2];
      REG_ORIGIN: prdata = {20'd0, origin_q};
      default:    prdata = '0;
    endcase
  end

  // Global pipeline advance.
  logic adv;
  logic out_valid_q;
  logic v1_q, v2_q, v3_q, v4_q, v5_q;

  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      v5_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      v1_q        <= s_axis_tvalid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      v5_q        <= v4_q;
      out_valid_q <= v5_q;
    end
  end

  // Stage 1: split coordinates and form corner addresses.
  logic [16:0]              pos   [3];
  logic [5:0]               base  [3];
  logic [5:0]               upper [3];
  logic signed [FRAC_W-1:0] frac  [3];
  logic [2:0]               ax_ok;

  assign pos[0] = s_axis_tdata_i[16:0];
  assign pos[1] = s_axis_tdata_i[33:17];
  assign pos[2] = s_axis_tdata_i[50:34];

  for (genvar a = 0; a < 3; a++) begin : g_split
    logic [4:0] ip;
    logic [4:0] ipc;
    assign ip  = pos[a][16:12];
    assign ipc = (ip == 5'd0) ? 5'd1 : ip;
    assign frac[a] = (ip == 5'd0) ? {1'b1, pos[a][11:0]} : {1'b0, pos[a][11:0]};
    assign base[a] = 6'(ipc) - 6'd1 + 6'(origin_q[4*a +: 4]);
    assign ax_ok[a] = 9'(base[a]) <= 9'(SIZE[a] - 1);
    assign upper[a] = (9'(base[a]) < 9'(SIZE[a] - 1)) ? base[a] + 6'd1 : base[a];
  end

  logic [STORE_AW-1:0] caddr [NUM_CORNERS];

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_addr
    logic [31:0] xi, yi, zi, fl;
    assign xi = 32'(((k & 1) != 0) ? upper[0] : base[0]);
    assign yi = 32'(((k & 2) != 0) ? upper[1] : base[1]);
    assign zi = 32'(((k & 4) != 0) ? upper[2] : base[2]);
    assign fl = xi + (yi + zi * GRID_Y) * GRID_X;
    assign caddr[k] = fl[STORE_AW-1:0];
  end

  meta_t                    meta1_q, meta2_q, meta3_q, meta4_q, meta5_q;
  logic signed [FRAC_W-1:0] frac1_q [3];
  logic signed [FRAC_W-1:0] fx2_q, fy2_q, fz2_q, fy3_q, fz3_q, fz4_q;
  logic [STORE_AW-1:0]      addr1_q [NUM_CORNERS];
  logic [STORE_AW-1:0]      waddr1_q;
  logic [3*COORD_W-1:0]     wdata1_q;

  always_ff @(posedge clk_i) begin
    if (adv) begin
      meta1_q.op <= op_e'(s_axis_tuser_i);
      meta1_q.ok <= &ax_ok;
      frac1_q    <= frac;
      addr1_q    <= caddr;
      waddr1_q   <= s_axis_tdata_i[62:51];
      wdata1_q   <= s_axis_tdata_i[158:63];
      meta2_q    <= meta1_q;
      fx2_q      <= frac1_q[0];
      fy2_q      <= frac1_q[1];
      fz2_q      <= frac1_q[2];
      meta3_q    <= meta2_q;
      fy3_q      <= fy2_q;
      fz3_q      <= fz2_q;
      meta4_q    <= meta3_q;
      fz4_q      <= fz3_q;
      meta5_q    <= meta4_q;
    end
  end

  // Stage 2: store copies, one per corner.
  logic load_wr;
  logic [3*COORD_W-1:0] corner_q [NUM_CORNERS];

  assign load_wr = adv && v1_q && (meta1_q.op == OP_LOAD);

  for (genvar k = 0; k < NUM_CORNERS; k++) begin : g_store
    logic [3*COORD_W-1:0] mem [STORE_DEPTH];
    always_ff @(posedge clk_i) begin
      if (load_wr) begin
        mem[waddr1_q] <= wdata1_q;
      end
      if (adv) begin
        corner_q[k] <= mem[addr1_q[k]];
      end
    end
  end

  // Stages 3 to 5: interpolate along x, then y, then z.
  logic signed [L3_W-1:0] l3 [3];

  for (genvar c = 0; c < 3; c++) begin : g_comp
    logic signed [L1_W-1:0] l1 [4];
    logic signed [L2_W-1:0] l2 [2];
    for (genvar j = 0; j < 4; j++) begin : g_l1
      gtcm_lerp #(.IN_W(COORD_W), .OUT_W(L1_W)) u_lerp (
        .clk_i  (clk_i),
        .en_i   (adv),
        .lo_i   (corner_q[2*j][COORD_W*c +: COORD_W]),
        .hi_i   (corner_q[2*j+1][COORD_W*c +: COORD_W]),
        .frac_i (fx2_q),
        .q_o    (l1[j])
      );
    end
    for (genvar m = 0; m < 2; m++) begin : g_l2
      gtcm_lerp #(.IN_W(L1_W), .OUT_W(L2_W)) u_lerp (
        .clk_i  (clk_i),
        .en_i   (adv),
        .lo_i   (l1[2*m]),
        .hi_i   (l1[2*m+1]),
        .frac_i (fy3_q),
        .q_o    (l2[m])
      );
    end
    gtcm_lerp #(.IN_W(L2_W), .OUT_W(L3_W)) u_lerp3 (
      .clk_i  (clk_i),
      .en_i   (adv),
      .lo_i   (l2[0]),
      .hi_i   (l2[1]),
      .frac_i (fz4_q),
      .q_o    (l3[c])
    );
  end

  // Stage 6: saturate, window check and output register.
  logic signed [31:0] res [3];
  logic [2:0]         outside;

  for (genvar c = 0; c < 3; c++) begin : g_win
    always_comb begin
      if (l3[c] > L3_W'(32'sh7FFF_FFFF)) begin
        res[c] = 32'sh7FFF_FFFF;
      end else if (l3[c] < L3_W'(32'sh8000_0000)) begin
        res[c] = 32'sh8000_0000;
      end else begin
        res[c] = 32'(l3[c]);
      end
      if (win_a_q[c] < win_b_q[c]) begin
        outside[c] = (res[c] < win_a_q[c]) || (res[c] > win_b_q[c]);
      end else begin
        outside[c] = (res[c] > win_a_q[c]) || (res[c] < win_b_q[c]);
      end
    end
  end

  logic [95:0] out_data_d, out_data_q;
  logic [1:0]  out_user_d, out_user_q;

  always_comb begin
    out_data_d = '0;
    out_user_d = '0;
    if (meta5_q.op == OP_MAP_WIN || meta5_q.op == OP_MAP_RAW) begin
      if (!meta5_q.ok) begin
        out_user_d[1] = 1'b1;
      end else begin
        out_data_d = {res[2], res[1], res[0]};
        if (meta5_q.op == OP_MAP_WIN && (|outside)) begin
          out_data_d[31:0] = 32'h7FFF_FFFF;
          out_user_d[0]    = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= out_data_d;
      out_user_q <= out_user_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  `GTCM_ASSERT_IMP(a_oog_zero, out_valid_q && out_user_q[1], out_data_q == 96'd0)
  `GTCM_ASSERT_IMP(a_clip_max, out_valid_q && out_user_q[0], out_data_q[31:0] == 32'h7FFF_FFFF)
  `GTCM_ASSERT_IMP(a_flags_excl, out_valid_q, !(out_user_q[0] && out_user_q[1]))
  `GTCM_ASSERT_NXT(a_stage_move, adv && v5_q, out_valid_q)

endmodule

>>> sim/grid_trilinear_coord_map_test.sv
`timescale 1ns / 1ps

module grid_trilinear_coord_map_test;
  import gtcm_pkg::*;

  localparam int unsigned GRID_N = 16;
  localparam int unsigned PIPE_WAIT = 12;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct {
    op_e          op;
    logic [16:0]  px;
    logic [16:0]  py;
    logic [16:0]  pz;
    logic [11:0]  addr;
    logic [31:0]  lx;
    logic [31:0]  ly;
    logic [31:0]  lz;
  } beat_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic        clip;
    logic        oog;
  } point_t;

  typedef struct {
    int     lo;
    int     hi;
    longint frac;
    bit     ok;
  } axis_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [159:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [95:0] m_tdata;
  logic [1:0] m_tuser;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  grid_trilinear_coord_map i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk_i = ~clk_i;

  beat_t  pending_beats[$];
  point_t expected_points[$];
  logic [31:0] store_x[GRID_N*GRID_N*GRID_N];
  logic [31:0] store_y[GRID_N*GRID_N*GRID_N];
  logic [31:0] store_z[GRID_N*GRID_N*GRID_N];
  bit loaded[GRID_N*GRID_N*GRID_N];
  logic [31:0] win_bound[6];
  logic [11:0] origin_cfg = '0;
  int mismatches = 0;
  int in_beats = 0;
  int stall_cycles = 0;
  bit quiet = 1'b0;
  bit in_beat_q = 1'b0;
  int send_gap = 0;
  int recv_gap = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic axis_t split_axis(logic [16:0] pos, logic [3:0] org);
    axis_t a;
    int ip;
    ip = int'(pos[16:12]);
    if (ip < 1) ip = 1;
    a.frac = longint'(pos) - longint'(ip) * 4096;
    a.lo = ip - 1 + int'(org);
    a.hi = (a.lo < GRID_N - 1) ? a.lo + 1 : a.lo;
    a.ok = a.lo <= GRID_N - 1;
    return a;
  endfunction

  function automatic int flat_index(int x, int y, int z);
    return (x + (y + z * GRID_N) * GRID_N) & 12'hFFF;
  endfunction

  function automatic longint blend(longint lo, longint hi, longint f);
    longint s;
    s = lo * (4096 - f) + hi * f + 2048;
    return s >>> 12;
  endfunction

  function automatic longint corner(int c, int idx);
    logic [31:0] v;
    v = (c == 0) ? store_x[idx] : (c == 1) ? store_y[idx] : store_z[idx];
    return longint'($signed(v));
  endfunction

  function automatic bit off_window(longint v, logic [31:0] ra, logic [31:0] rb);
    longint a, b;
    a = longint'($signed(ra));
    b = longint'($signed(rb));
    if (a < b) return v < a || v > b;
    return v > a || v < b;
  endfunction

  function automatic point_t map_point(beat_t bt);
    point_t p;
    axis_t ax, ay, az;
    longint res[3];
    longint y0z0, y1z0, y0z1, y1z1, z0, z1;
    p = '{default: '0};
    ax = split_axis(bt.px, origin_cfg[3:0]);
    ay = split_axis(bt.py, origin_cfg[7:4]);
    az = split_axis(bt.pz, origin_cfg[11:8]);
    if (!(ax.ok && ay.ok && az.ok)) begin
      p.oog = 1'b1;
      return p;
    end
    for (int c = 0; c < 3; c++) begin
      y0z0 = blend(corner(c, flat_index(ax.lo, ay.lo, az.lo)),
                   corner(c, flat_index(ax.hi, ay.lo, az.lo)), ax.frac);
      y1z0 = blend(corner(c, flat_index(ax.lo, ay.hi, az.lo)),
                   corner(c, flat_index(ax.hi, ay.hi, az.lo)), ax.frac);
      y0z1 = blend(corner(c, flat_index(ax.lo, ay.lo, az.hi)),
                   corner(c, flat_index(ax.hi, ay.lo, az.hi)), ax.frac);
      y1z1 = blend(corner(c, flat_index(ax.lo, ay.hi, az.hi)),
                   corner(c, flat_index(ax.hi, ay.hi, az.hi)), ax.frac);
      z0 = blend(y0z0, y1z0, ay.frac);
      z1 = blend(y0z1, y1z1, ay.frac);
      res[c] = blend(z0, z1, az.frac);
      if (res[c] > 64'sd2147483647) res[c] = 64'sd2147483647;
      if (res[c] < -64'sd2147483648) res[c] = -64'sd2147483648;
    end
    if (bt.op == OP_MAP_WIN && (off_window(res[0], win_bound[0], win_bound[1]) ||
                                off_window(res[1], win_bound[2], win_bound[3]) ||
                                off_window(res[2], win_bound[4], win_bound[5]))) begin
      res[0] = 64'sd2147483647;
      p.clip = 1'b1;
    end
    p.x = res[0][31:0];
    p.y = res[1][31:0];
    p.z = res[2][31:0];
    return p;
  endfunction

  // Sender side.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_beat_q) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0 && !quiet && $urandom_range(0, 11) == 0) begin
        send_gap <= $urandom_range(1, 7) - 1;
        s_tvalid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        beat_t bt;
        bt = pending_beats.pop_front();
        s_tdata <= {1'b0, bt.lz, bt.ly, bt.lx, bt.addr, bt.pz, bt.py, bt.px};
        s_tuser <= bt.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver side, including one long hold-off that fills the pipeline.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (!hold_done && in_beats >= 300) begin
      hold_done <= 1'b1;
      hold_left <= 250;
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      m_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      recv_gap <= $urandom_range(1, 7) - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    beat_t bt;
    point_t got, want;
    in_beat_q <= s_tvalid && s_tready;
    if (s_tvalid && s_tready) begin
      bt.op = op_e'(s_tuser);
      {bt.lz, bt.ly, bt.lx, bt.addr, bt.pz, bt.py, bt.px} = s_tdata[158:0];
      in_beats <= in_beats + 1;
      if (bt.op == OP_LOAD) begin
        store_x[bt.addr] = bt.lx;
        store_y[bt.addr] = bt.ly;
        store_z[bt.addr] = bt.lz;
        expected_points.push_back('{default: '0});
      end else if (bt.op == OP_NONE) begin
        expected_points.push_back('{default: '0});
      end else begin
        expected_points.push_back(map_point(bt));
      end
    end
    if (m_tvalid && m_tready) begin
      {got.z, got.y, got.x} = m_tdata;
      {got.oog, got.clip} = m_tuser;
      if (expected_points.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h %b", m_tdata, m_tuser);
      end else begin
        want = expected_points.pop_front();
        if (got.x !== want.x || got.y !== want.y || got.z !== want.z ||
            got.clip !== want.clip || got.oog !== want.oog) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected x=%h y=%h z=%h clip=%b oog=%b, got x=%h y=%h z=%h clip=%b oog=%b",
                     want.x, want.y, want.z, want.clip, want.oog,
                     got.x, got.y, got.z, got.clip, got.oog);
        end
      end
    end
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable) || !rst_ni)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic write_reg(reg_e idx, logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_ORIGIN) origin_cfg = value[11:0];
    else win_bound[idx] = value;
  endtask

  task automatic wait_idle();
    wait (pending_beats.size() == 0 && !s_tvalid);
    wait (expected_points.size() == 0);
    repeat (PIPE_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [31:0] point_value();
    case ($urandom_range(0, 3))
      0: return 32'h8000_0000 | $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_load(logic [11:0] addr, logic [31:0] x, logic [31:0] y,
                           logic [31:0] z);
    beat_t bt;
    bt = '{op: OP_LOAD, px: 17'($urandom), py: 17'($urandom), pz: 17'($urandom),
           addr: addr, lx: x, ly: y, lz: z};
    loaded[addr] = 1'b1;
    pending_beats.push_back(bt);
  endtask

  // Queues a map beat, first loading any corner the map would read unwritten.
  task automatic push_map(op_e op, logic [16:0] px, logic [16:0] py, logic [16:0] pz);
    beat_t bt;
    axis_t ax, ay, az;
    int idx;
    ax = split_axis(px, origin_cfg[3:0]);
    ay = split_axis(py, origin_cfg[7:4]);
    az = split_axis(pz, origin_cfg[11:8]);
    if (ax.ok && ay.ok && az.ok) begin
      for (int c = 0; c < 8; c++) begin
        idx = flat_index(c[0] ? ax.hi : ax.lo, c[1] ? ay.hi : ay.lo, c[2] ? az.hi : az.lo);
        if (!loaded[idx]) push_load(12'(idx), point_value(), point_value(), point_value());
      end
    end
    bt = '{op: op, px: px, py: py, pz: pz, addr: 12'($urandom), lx: $urandom,
           ly: $urandom, lz: $urandom};
    pending_beats.push_back(bt);
  endtask

  // Positions cluster at the low and high grid edges; the rest fall past the grid.
  function automatic logic [16:0] rand_pos(logic [3:0] org);
    int ip;
    if ($urandom_range(0, 9) == 0)
      return {5'($urandom_range(17 - int'(org), 31)), 12'($urandom)};
    if ($urandom_range(0, 1) == 0) ip = int'($urandom_range(0, 2));
    else ip = 16 - int'(org) - int'($urandom_range(0, 2));
    if (ip < 0) ip = 0;
    return {5'(ip), 12'($urandom)};
  endfunction

  task automatic random_phase(int count);
    op_e op;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 19))
        0, 1, 2: push_load(12'($urandom_range(0, 4095)), point_value(), point_value(),
                           point_value());
        3: begin
          pending_beats.push_back('{op: OP_NONE, px: 17'($urandom), py: 17'($urandom),
                                    pz: 17'($urandom), addr: 12'($urandom),
                                    lx: $urandom, ly: $urandom, lz: $urandom});
        end
        default: begin
          op = $urandom_range(0, 1) ? OP_MAP_WIN : OP_MAP_RAW;
          push_map(op, rand_pos(origin_cfg[3:0]), rand_pos(origin_cfg[7:4]),
                   rand_pos(origin_cfg[11:8]));
        end
      endcase
    end
  endtask

  initial begin
    win_bound = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                  32'h8000_0000, 32'h7FFF_FFFF};
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_reg(REG_WIN_XA, 32'hFFF0_0000);
    write_reg(REG_WIN_XB, 32'h0010_0000);
    write_reg(REG_WIN_YA, 32'h8000_0000);
    write_reg(REG_WIN_YB, 32'h7FFF_FFFF);
    write_reg(REG_WIN_ZA, 32'h7FFF_FFFF);
    write_reg(REG_WIN_ZB, 32'h8000_0000);
    write_reg(REG_ORIGIN, 32'h0000_0000);

    // Directed: value extremes, integer part zero, grid edge, out of grid, unused op.
    push_load(12'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000);
    push_load(12'd1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF);
    push_load(12'hFFF, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
    push_map(OP_MAP_RAW, 17'h00000, 17'h00000, 17'h00000);
    push_map(OP_MAP_RAW, 17'h00001, 17'h01000, 17'h01FFF);
    push_map(OP_MAP_WIN, 17'h01800, 17'h01000, 17'h01000);
    push_map(OP_MAP_WIN, 17'h00000, 17'h01000, 17'h01000);
    push_map(OP_MAP_RAW, 17'h10FFF, 17'h10FFF, 17'h10FFF);
    push_map(OP_MAP_WIN, 17'h10000, 17'h0F800, 17'h01000);
    push_map(OP_MAP_RAW, 17'h11000, 17'h01000, 17'h01000);
    push_map(OP_MAP_RAW, 17'h01000, 17'h1FFFF, 17'h01000);
    push_map(OP_MAP_WIN, 17'h01000, 17'h01000, 17'h1F000);
    pending_beats.push_back('{op: OP_NONE, px: '1, py: '1, pz: '1, addr: '1,
                              lx: '1, ly: '1, lz: '1});
    push_map(OP_MAP_RAW, 17'h01000, 17'h01000, 17'h01000);
    random_phase(450);
    wait_idle();

    write_reg(REG_WIN_XA, $urandom);
    write_reg(REG_WIN_XB, $urandom);
    write_reg(REG_WIN_YA, $urandom_range(0, 32'h0100_0000) - 32'h0080_0000);
    write_reg(REG_WIN_YB, 32'h8000_0000);
    write_reg(REG_ORIGIN, $urandom_range(0, 12'h777));
    random_phase(300);
    wait_idle();

    write_reg(REG_WIN_XA, 32'h0000_0000);
    write_reg(REG_WIN_XB, 32'h0000_0000);
    write_reg(REG_ORIGIN, 32'h0000_0FFF);
    push_map(OP_MAP_WIN, 17'h00000, 17'h00000, 17'h00000);
    random_phase(200);
    wait_idle();

    write_reg(REG_WIN_XA, 32'h7FFF_FFFF);
    write_reg(REG_WIN_XB, 32'h8000_0000);
    write_reg(REG_WIN_YA, 32'h7FFF_FFFF);
    write_reg(REG_WIN_YB, 32'h8000_0000);
    write_reg(REG_WIN_ZA, 32'hFF00_0000);
    write_reg(REG_WIN_ZB, 32'h0100_0000);
    write_reg(REG_ORIGIN, $urandom_range(0, 12'h333));
    quiet = 1'b1;
    random_phase(400);
    wait_idle();

    if (mismatches == 0 && expected_points.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gtcm_pkg.sv
rtl/gtcm_lerp.sv
rtl/grid_trilinear_coord_map.sv
sim/grid_trilinear_coord_map_test.sv
